// ===== rtl/stable_record_sort_by_key_unit_macros.svh =====
// Assertion macros for the stable record sorter.
// No dependencies; included by modules that carry assertions.
`ifndef STABLE_RECORD_SORT_BY_KEY_UNIT_MACROS_SVH
`define STABLE_RECORD_SORT_BY_KEY_UNIT_MACROS_SVH

// Assert that a condition holds at every rising clock edge outside reset.
`define SRS_ASSERT_IMPL(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Assert that a signal is never high outside reset.
`define SRS_ASSERT_NEVER(label, clk, rst, sig, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(sig)) else $error(msg);

`endif

// ===== rtl/srsort_pkg.sv =====
// Shared types and constants for the stable record sorter.
// No dependencies.
package srsort_pkg;
  localparam int DEPTH_DEFAULT = 64;
  localparam int KEY_W = 30;
  localparam int START_W = 30;
  localparam int VALUE_W = 32;
  localparam int MASK_W = 4;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [START_W-1:0] start;
    logic [VALUE_W-1:0] value;
    logic [MASK_W-1:0]  mask;
  } rec_t;

  // Command from the front part to the back part.
  typedef struct packed {
    rec_t rec;
    logic store;   // write the record into the next slot
    logic close;   // set is complete, sort and emit
  } cmd_t;
endpackage

// ===== rtl/stable_record_sort_by_key_unit.sv =====
// Top level of the stable record sorter: front queue plus sorting back end.
// Depends on srsort_pkg, srsort_front and srsort_back.
//
// Channel   | Handshake            | Payload
// ----------+----------------------+------------------------------------------
// records   | start / busy         | sort_key record_start record_value
//           |                      | channel_mask is_last
// results   | out_valid strobe     | out_key out_start out_value out_mask
//           |                      | out_last overflow
//
// Records transfer one per cycle while the two-entry queue has room and no
// closed set is still sorting. After the last record each result needs a full
// key scan over the held records through the memory read port, then a read
// state and an emit state.
// Reset is synchronous on rst and empties the store; the receiver cannot
// stall, so each result is shown for exactly one cycle.
module stable_record_sort_by_key_unit import srsort_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [KEY_W-1:0]   sort_key,
  input  logic [START_W-1:0] record_start,
  input  logic [VALUE_W-1:0] record_value,
  input  logic [MASK_W-1:0]  channel_mask,
  input  logic               is_last,
  output logic               out_valid,
  output logic [KEY_W-1:0]   out_key,
  output logic [START_W-1:0] out_start,
  output logic [VALUE_W-1:0] out_value,
  output logic [MASK_W-1:0]  out_mask,
  output logic               out_last,
  output logic               overflow
);
  rec_t rec_in, res_rec;
  cmd_t q_head;
  logic take, q_valid, q_full, ovf_drop, pop;
  logic closing;

  // hold off new records while a set is closed and still sorting
  always_ff @(posedge clk) begin
    if (rst) closing <= 1'b0;
    else if (take && is_last) closing <= 1'b1;
    else if (out_valid && out_last) closing <= 1'b0;
  end

  assign busy = q_full || closing;
  assign take = start && !busy;
  assign rec_in = '{key: sort_key, start: record_start, value: record_value,
                    mask: channel_mask};

  srsort_front #(.DEPTH(DEPTH)) u_front (
    .clk, .rst, .take, .rec_in, .last_in(is_last), .pop,
    .q_valid, .q_head, .q_full, .ovf_drop
  );

  srsort_back #(.DEPTH(DEPTH)) u_back (
    .clk, .rst, .q_valid, .q_head, .ovf_drop, .pop,
    .res_valid(out_valid), .res_rec, .res_last(out_last), .res_ovf(overflow)
  );

  assign out_key   = res_rec.key;
  assign out_start = res_rec.start;
  assign out_value = res_rec.value;
  assign out_mask  = res_rec.mask;
endmodule

// ===== rtl/srsort_front.sv =====
// Front part: accepts records, classifies them and queues commands.
// Depends on srsort_pkg.
module srsort_front import srsort_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic take,
  input  rec_t rec_in,
  input  logic last_in,
  input  logic pop,
  output logic q_valid,
  output cmd_t q_head,
  output logic q_full,
  output logic ovf_drop
);
  localparam int CW = $clog2(DEPTH + 1);
  cmd_t q [QUEUE_DEPTH];
  logic [1:0] q_count;
  logic       rd_ptr, wr_ptr;
  logic [CW-1:0] accepted;
  logic          stored;

  assign stored  = (accepted < CW'(DEPTH));
  assign q_valid = (q_count != 2'd0);
  assign q_full  = (q_count == 2'(QUEUE_DEPTH));
  assign q_head  = q[rd_ptr];
  assign ovf_drop = take && !stored;

  always_ff @(posedge clk) begin
    if (take) begin
      q[wr_ptr].rec   <= rec_in;
      q[wr_ptr].store <= stored;
      q[wr_ptr].close <= last_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_count  <= '0;
      rd_ptr   <= 1'b0;
      wr_ptr   <= 1'b0;
      accepted <= '0;
    end else begin
      if (take) begin
        wr_ptr <= ~wr_ptr;
        if (last_in) accepted <= '0;
        else if (stored) accepted <= accepted + CW'(1);
      end
      if (pop) rd_ptr <= ~rd_ptr;
      q_count <= q_count + 2'(take) - 2'(pop);
    end
  end
endmodule

// ===== rtl/srsort_back.sv =====
// Back part: stores records and emits them by repeated minimum search.
// Depends on srsort_pkg and the assertion macro header.
`include "stable_record_sort_by_key_unit_macros.svh"
module srsort_back import srsort_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  cmd_t q_head,
  input  logic ovf_drop,
  output logic pop,
  output logic res_valid,
  output rec_t res_rec,
  output logic res_last,
  output logic res_ovf
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_LOAD = 4'b0001, S_SCAN = 4'b0010, S_READ = 4'b0100, S_EMIT = 4'b1000
  } state_t;

  rec_t mem [DEPTH];
  logic [DEPTH-1:0] done;
  state_t state;
  logic [CW-1:0] count, emitted;
  logic [AW-1:0] scan, best;
  logic [KEY_W-1:0] best_key;
  logic best_ok, ovf;
  rec_t rd_data;
  logic [KEY_W-1:0] key_rd;
  logic [AW-1:0] key_addr;
  logic [AW-1:0] scan_prev;
  logic          scan_prev_ok;
  logic          scan_end;

  assign pop  = (state == S_LOAD) && q_valid;
  assign key_addr = scan;
  assign scan_end = (CW'(scan) == count - CW'(1));

  always_ff @(posedge clk) begin
    if (pop && q_head.store) mem[count[AW-1:0]] <= q_head.rec;
    key_rd  <= mem[key_addr].key;
    rd_data <= mem[best];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD; count <= '0; emitted <= '0; done <= '0;
      ovf <= 1'b0; scan <= '0; best <= '0; best_key <= '0; best_ok <= 1'b0;
      scan_prev <= '0; scan_prev_ok <= 1'b0;
      res_valid <= 1'b0; res_rec <= '0; res_last <= 1'b0; res_ovf <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      if (ovf_drop) ovf <= 1'b1;
      unique case (state)
        S_LOAD: begin
          if (pop) begin
            if (q_head.store) count <= count + CW'(1);
            if (q_head.close) begin
              state <= S_SCAN; scan <= '0; best_ok <= 1'b0;
              scan_prev_ok <= 1'b0; emitted <= '0; done <= '0;
            end
          end
        end
        S_SCAN: begin
          // key_rd holds the key of scan_prev; strict compare keeps stability
          if (scan_prev_ok && !done[scan_prev] &&
              (!best_ok || key_rd < best_key)) begin
            best <= scan_prev; best_key <= key_rd; best_ok <= 1'b1;
          end
          scan_prev <= scan;
          scan_prev_ok <= !scan_prev_ok || (scan != scan_prev) || scan == '0;
          if (scan_prev_ok && scan_prev == scan) begin
            state <= S_READ;
          end else if (!scan_end) begin
            scan <= scan + AW'(1);
          end
        end
        S_READ: state <= S_EMIT;
        S_EMIT: begin
          res_valid <= 1'b1;
          res_rec   <= rd_data;
          res_last  <= (emitted == count - CW'(1));
          res_ovf   <= ovf;
          done[best] <= 1'b1;
          if (emitted == count - CW'(1)) begin
            state <= S_LOAD; count <= '0; ovf <= 1'b0;
          end else begin
            emitted <= emitted + CW'(1);
            state <= S_SCAN; scan <= '0; best_ok <= 1'b0; scan_prev_ok <= 1'b0;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  `SRS_ASSERT_IMPL(a_onehot, clk, rst, $onehot(state), "state not one-hot")
  `SRS_ASSERT_IMPL(a_cnt, clk, rst, count <= CW'(DEPTH), "count beyond depth")
  `SRS_ASSERT_NEVER(a_pop, clk, rst, pop && state != S_LOAD, "pop outside load")
endmodule

// ===== test/stable_record_sort_by_key_unit_checker.sv =====
// Checker for the stable record sorter: predicts sorted runs and compares results.
// Depends on srsort_pkg; instantiated beside the block by the testbench top.
module stable_record_sort_by_key_unit_checker import srsort_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [KEY_W-1:0]   sort_key,
  input  logic [START_W-1:0] record_start,
  input  logic [VALUE_W-1:0] record_value,
  input  logic [MASK_W-1:0]  channel_mask,
  input  logic               is_last,
  input  logic               out_valid,
  input  logic [KEY_W-1:0]   out_key,
  input  logic [START_W-1:0] out_start,
  input  logic [VALUE_W-1:0] out_value,
  input  logic [MASK_W-1:0]  out_mask,
  input  logic               out_last,
  input  logic               overflow,
  output int                 fail_count,
  output int                 pending_count,
  output int                 runs_seen,
  output int                 overflow_runs
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    rec_t rec;
    logic last;
    logic ovf;
  } sorted_rec_t;

  rec_t        held_recs[$];
  logic        dropped;
  sorted_rec_t sorted_due[$];

  // Stable insertion sort of the held set; push the ordered run.
  task automatic emit_sorted_run();
    rec_t        ord[$];
    rec_t        cur;
    sorted_rec_t s;
    int          j;
    ord = held_recs;
    for (int i = 1; i < ord.size(); i++) begin
      cur = ord[i];
      j = i;
      while (j > 0 && ord[j-1].key > cur.key) begin
        ord[j] = ord[j-1];
        j--;
      end
      ord[j] = cur;
    end
    for (int k = 0; k < ord.size(); k++) begin
      s.rec  = ord[k];
      s.last = (k == ord.size() - 1);
      s.ovf  = dropped;
      sorted_due.push_back(s);
    end
    if (dropped) overflow_runs++;
    runs_seen++;
    held_recs.delete();
    dropped = 1'b0;
  endtask

  always @(posedge clk) begin
    sorted_rec_t e;
    rec_t        r;
    if (rst) begin
      held_recs.delete();
      sorted_due.delete();
      dropped = 1'b0;
      fail_count = 0;
      runs_seen = 0;
      overflow_runs = 0;
    end else begin
      if (out_valid) begin
        if (sorted_due.size() == 0) begin
          $display("%0t: unexpected result key=%h start=%h value=%h mask=%h",
                   $time, out_key, out_start, out_value, out_mask);
          fail_count++;
        end else begin
          e = sorted_due.pop_front();
          if (out_key !== e.rec.key || out_start !== e.rec.start ||
              out_value !== e.rec.value || out_mask !== e.rec.mask ||
              out_last !== e.last || overflow !== e.ovf) begin
            $display("%0t: mismatch expected k=%h s=%h v=%h m=%h l=%b o=%b", $time,
                     e.rec.key, e.rec.start, e.rec.value, e.rec.mask, e.last, e.ovf);
            $display("%0t:          actual   k=%h s=%h v=%h m=%h l=%b o=%b", $time,
                     out_key, out_start, out_value, out_mask, out_last, overflow);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        r.key = sort_key;
        r.start = record_start;
        r.value = record_value;
        r.mask = channel_mask;
        if (held_recs.size() < DEPTH) held_recs.push_back(r);
        else dropped = 1'b1;
        if (is_last) emit_sorted_run();
      end
    end
    pending_count = sorted_due.size();
  end
endmodule

// ===== test/tb_stable_record_sort_by_key_unit.sv =====
// Testbench top for the stable record sorter: stimulus, clock, reset, verdict.
// Depends on srsort_pkg, the block and stable_record_sort_by_key_unit_checker.
module tb_stable_record_sort_by_key_unit;
  import srsort_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam longint CYCLE_LIMIT = 4_000_000;
  localparam logic [KEY_W-1:0] KEY_TOP = '1;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [KEY_W-1:0]   sort_key = '0;
  logic [START_W-1:0] record_start = '0;
  logic [VALUE_W-1:0] record_value = '0;
  logic [MASK_W-1:0]  channel_mask = '0;
  logic               is_last = 1'b0;
  logic               out_valid;
  logic [KEY_W-1:0]   out_key;
  logic [START_W-1:0] out_start;
  logic [VALUE_W-1:0] out_value;
  logic [MASK_W-1:0]  out_mask;
  logic               out_last;
  logic               overflow;
  int                 fail_count, pending_count, runs_seen, overflow_runs;
  int                 records_sent = 0;
  longint             cycle_count = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  stable_record_sort_by_key_unit #(.DEPTH(DEPTH)) u_dut (.*);

  stable_record_sort_by_key_unit_checker #(.DEPTH(DEPTH)) u_check (.*);

  // Guard against a hung block: a run that goes past the cycle limit is a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Idle the sender for a random spell: mostly short, now and then long.
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Offer one record and hold it until the transfer happens.
  task automatic send_record(input logic [KEY_W-1:0] k, input logic [START_W-1:0] s,
                             input logic [VALUE_W-1:0] v, input logic [MASK_W-1:0] m,
                             input logic lst, input bit gaps);
    if (gaps) idle_gap();
    start <= 1'b1;
    sort_key <= k;
    record_start <= s;
    record_value <= v;
    channel_mask <= m;
    is_last <= lst;
    do @(posedge clk); while (busy);
    @(negedge clk);
    records_sent++;
  endtask

  // Random key drawn mostly from narrow pools so equal keys are common.
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 4))
      0: return KEY_W'($urandom_range(0, 7));
      1: return KEY_TOP - KEY_W'($urandom_range(0, 3));
      2: return 30'd900000000 + KEY_W'($urandom_range(0, 2));
      default: return KEY_W'($urandom());
    endcase
  endfunction

  // Send a whole set of n records with random content; the final one closes it.
  task automatic send_set(input int n, input bit gaps);
    for (int i = 0; i < n; i++)
      send_record(pick_key(), START_W'($urandom()), $urandom(),
                  MASK_W'($urandom_range(0, 15)), i == n - 1, gaps);
  endtask

  // Drop start and hold off until every expected result has come.
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending_count != 0 || busy) @(negedge clk);
  endtask

  initial begin
    int n;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: a single-record set, extremes, and a tie run.
    send_record(KEY_TOP, '1, '1, 4'hF, 1'b1, 1'b0);
    send_record('0, '0, '0, 4'h0, 1'b0, 1'b0);
    send_record(KEY_TOP, '1, '1, 4'hF, 1'b0, 1'b0);
    send_record(30'd5, 30'd1, 32'd1, 4'h1, 1'b0, 1'b0);
    send_record(30'd5, 30'd2, 32'd2, 4'h2, 1'b0, 1'b0);
    send_record('0, 30'h2AAAAAAA, 32'h55555555, 4'hA, 1'b0, 1'b0);
    send_record(30'd5, 30'h15555555, 32'hAAAAAAAA, 4'h5, 1'b1, 1'b0);
    drain();
    // Store full: the last-marked record itself is dropped.
    send_set(DEPTH + 2, 1'b0);
    drain();

    // Random: mostly short sets, a few around or past the depth.
    while (records_sent < 460) begin
      case ($urandom_range(0, 15))
        0: n = DEPTH - 1 + $urandom_range(0, 3);
        1, 2: n = $urandom_range(9, 24);
        default: n = $urandom_range(1, 8);
      endcase
      send_set(n, $urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0) drain();
    end

    drain();
    repeat (200) @(negedge clk);
    $display("covered %0d records in %0d sorted runs, %0d of them with dropped records",
             records_sent, runs_seen, overflow_runs);
    if (fail_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ===== stable_record_sort_by_key_unit.f =====
+incdir+rtl
rtl/srsort_pkg.sv
rtl/srsort_front.sv
rtl/srsort_back.sv
rtl/stable_record_sort_by_key_unit.sv
test/stable_record_sort_by_key_unit_checker.sv
test/tb_stable_record_sort_by_key_unit.sv
